// File: hw/rtl/ketq_pkg.sv
// ----------------------------------------------------------------------------
// ketq_pkg - shared types and constants for the keyed edit table
// Entry layout, status codes, sequencer states and word field widths.
// ----------------------------------------------------------------------------
package ketq_pkg;

	localparam int COORD_W  = 32;
	localparam int VALUE_W  = 16;
	localparam int REGION_W = 27;
	localparam int FILL_W   = 7;
	localparam int STATUS_W = 3;

	// region bound p * size: 27-bit index times a size of at most 512
	localparam int LO_W   = 36;
	// coordinate minus region bound
	localparam int DIFF_W = 37;

	localparam int S_DATA_W = 168;
	localparam int M_DATA_W = 128;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [VALUE_W-1:0] v;
	} entry_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_UPDATED  = 3'd0,
		STAT_REMOVED  = 3'd1,
		STAT_APPENDED = 3'd2,
		STAT_DEL_MISS = 3'd3,
		STAT_FULL     = 3'd4,
		STAT_MATCH    = 3'd5,
		STAT_NO_MATCH = 3'd6,
		STAT_DISABLED = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_DONE,
		ST_MOVE_RD,
		ST_MOVE_WR
	} state_t;

endpackage

// File: hw/rtl/keyed_edit_table_with_region_query_core.sv
// ----------------------------------------------------------------------------
// keyed_edit_table_with_region_query_core - keyed table with region lookup
// Linear-scan table of (x,y,z) keyed values held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data writes the enable bit; cfg_ready is always
//   high. Write it only while the block is idle.
//   The s_t* channel takes one command word. s_tuser selects the command
//   (0 writes an edit at the key, 1 queries a region). Each write gives one
//   result word; a query gives one word per matching entry in table order,
//   or a single no-match word, with m_tlast on the final word.
//   The entries are read one per cycle from the memory's single read port,
//   while the output register can take a word; a removal that moves the
//   last entry into the hole adds an extra read and write-back. A write
//   hit stops the scan early. One command is in work at a time. While
//   enable is clear, each command gives a single disabled word.
//   A result word waits in the output register while m_tready is low; the
//   scan holds in place until that register is free, so no word is lost.
//   A new command word is taken as soon as the previous one has finished,
//   even if its last result is still waiting to be taken.
//   Reset empties the table (fill count zero) and clears enable; the
//   memory itself is not cleared, as only entries below the fill count are
//   ever read.
// ----------------------------------------------------------------------------
module keyed_edit_table_with_region_query_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int REGION_SIZE = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,   // enable

	input  logic                           s_tvalid,
	output logic                           s_tready,
	// pos_x, pos_y, pos_z, new_value, region_p, region_q, zero pad
	input  logic [ketq_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,    // action

	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status, entry_x, entry_y, entry_z, entry_value, fill_count, zero pad
	output logic [ketq_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                           m_tlast
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	ketq_pkg::state_t state_q, state_d;
	logic enable_q;

	// latched command
	logic act_q;
	logic [ketq_pkg::COORD_W-1:0] px_q, py_q, pz_q;
	logic [ketq_pkg::VALUE_W-1:0] nv_q;
	logic signed [ketq_pkg::LO_W-1:0] lo_x_q, lo_z_q;

	// table memory and its read stage
	ketq_pkg::entry_t table_q [TABLE_DEPTH];
	ketq_pkg::entry_t rdata_s1;
	logic [AW-1:0] idx_s1;
	logic dv_s1_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [AW-1:0] hit_idx_q;

	// one query match held back until we know whether it is the last
	ketq_pkg::entry_t held_q;
	logic held_v_q;

	// output register
	logic m_tvalid_q;
	ketq_pkg::status_t out_stat_q;
	ketq_pkg::entry_t out_ent_q;
	logic [ketq_pkg::FILL_W-1:0] out_fill_q;
	logic out_last_q;

	// ------------------------------------------------------------------
	// Combinational control
	// ------------------------------------------------------------------
	logic adv;
	logic s_acc;
	logic key_hit, region_hit, stop;
	logic [CW-1:0] last_idx;
	logic signed [ketq_pkg::LO_W-1:0] rp_ext, rq_ext, rsize;
	logic signed [ketq_pkg::DIFF_W-1:0] diff_x, diff_z;

	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic we;
	logic [AW-1:0] wr_addr;
	ketq_pkg::entry_t wr_data;
	logic emit_v;
	ketq_pkg::status_t emit_stat;
	ketq_pkg::entry_t emit_ent;
	logic [CW-1:0] emit_cnt;
	logic emit_last;
	logic hold_load;
	logic count_inc, count_dec;

	// advance only when the output register can take a word
	assign adv       = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ketq_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign last_idx = count_q - 1'b1;

	// region bound p * size, sign extended before the product
	assign rp_ext = ketq_pkg::LO_W'($signed(s_tdata[138:112]));
	assign rq_ext = ketq_pkg::LO_W'($signed(s_tdata[165:139]));
	assign rsize  = ketq_pkg::LO_W'(REGION_SIZE);

	// floor(c / size) == p  <=>  0 <= c - p*size < size
	assign diff_x = ketq_pkg::DIFF_W'($signed(rdata_s1.x)) - ketq_pkg::DIFF_W'(lo_x_q);
	assign diff_z = ketq_pkg::DIFF_W'($signed(rdata_s1.z)) - ketq_pkg::DIFF_W'(lo_z_q);
	assign region_hit = !diff_x[ketq_pkg::DIFF_W-1] &&
		($unsigned(diff_x) < ketq_pkg::DIFF_W'(REGION_SIZE)) &&
		!diff_z[ketq_pkg::DIFF_W-1] &&
		($unsigned(diff_z) < ketq_pkg::DIFF_W'(REGION_SIZE));

	assign key_hit = (rdata_s1.x == px_q) && (rdata_s1.y == py_q) && (rdata_s1.z == pz_q);
	assign stop    = dv_s1_q && (act_q == ketq_pkg::ACT_WRITE) && key_hit;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ketq_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = ketq_pkg::ST_START;
			end
			ketq_pkg::ST_START: begin
				if (adv) state_d = enable_q ? ketq_pkg::ST_SCAN : ketq_pkg::ST_IDLE;
			end
			ketq_pkg::ST_SCAN: begin
				if (adv) begin
					priority if (stop) begin
						state_d = (nv_q == '0) ? ketq_pkg::ST_MOVE_RD : ketq_pkg::ST_IDLE;
					end else if (!dv_s1_q && (rd_idx_q >= count_q)) begin
						state_d = ketq_pkg::ST_DONE;
					end else begin
						state_d = ketq_pkg::ST_SCAN;
					end
				end
			end
			ketq_pkg::ST_DONE: begin
				if (adv) state_d = ketq_pkg::ST_IDLE;
			end
			ketq_pkg::ST_MOVE_RD: begin
				if (adv) state_d = ketq_pkg::ST_MOVE_WR;
			end
			ketq_pkg::ST_MOVE_WR: begin
				if (adv) state_d = ketq_pkg::ST_IDLE;
			end
			default: state_d = ketq_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = rd_idx_q[AW-1:0];
		we        = 1'b0;
		wr_addr   = idx_s1;
		wr_data   = '{x: px_q, y: py_q, z: pz_q, v: nv_q};
		emit_v    = 1'b0;
		emit_stat = ketq_pkg::STAT_DISABLED;
		emit_ent  = '0;
		emit_cnt  = count_q;
		emit_last = 1'b1;
		hold_load = 1'b0;
		count_inc = 1'b0;
		count_dec = 1'b0;
		unique case (state_q)
			ketq_pkg::ST_IDLE: begin
			end
			ketq_pkg::ST_START: begin
				if (adv && !enable_q) begin
					emit_v    = 1'b1;
					emit_stat = ketq_pkg::STAT_DISABLED;
				end
			end
			ketq_pkg::ST_SCAN: begin
				if (adv) begin
					// issue the next read unless a write hit ends the scan
					rd_en = (rd_idx_q < count_q) && !stop;
					if (stop && (nv_q != '0)) begin
						we        = 1'b1;
						emit_v    = 1'b1;
						emit_stat = ketq_pkg::STAT_UPDATED;
						emit_ent  = '{x: px_q, y: py_q, z: pz_q, v: nv_q};
					end
					if (dv_s1_q && (act_q == ketq_pkg::ACT_QUERY) && region_hit) begin
						hold_load = 1'b1;
						if (held_v_q) begin
							emit_v    = 1'b1;
							emit_stat = ketq_pkg::STAT_MATCH;
							emit_ent  = held_q;
							emit_last = 1'b0;
						end
					end
				end
			end
			ketq_pkg::ST_DONE: begin
				if (adv) begin
					emit_v = 1'b1;
					if (act_q == ketq_pkg::ACT_QUERY) begin
						if (held_v_q) begin
							emit_stat = ketq_pkg::STAT_MATCH;
							emit_ent  = held_q;
						end else begin
							emit_stat = ketq_pkg::STAT_NO_MATCH;
						end
					end else if (nv_q == '0) begin
						emit_stat = ketq_pkg::STAT_DEL_MISS;
						emit_ent  = '{x: px_q, y: py_q, z: pz_q, v: '0};
					end else if (count_q >= CW'(TABLE_DEPTH)) begin
						emit_stat = ketq_pkg::STAT_FULL;
						emit_ent  = '{x: px_q, y: py_q, z: pz_q, v: nv_q};
					end else begin
						we        = 1'b1;
						wr_addr   = count_q[AW-1:0];
						count_inc = 1'b1;
						emit_stat = ketq_pkg::STAT_APPENDED;
						emit_ent  = '{x: px_q, y: py_q, z: pz_q, v: nv_q};
						emit_cnt  = count_q + 1'b1;
					end
				end
			end
			ketq_pkg::ST_MOVE_RD: begin
				if (adv) begin
					rd_en   = 1'b1;
					rd_addr = last_idx[AW-1:0];
				end
			end
			ketq_pkg::ST_MOVE_WR: begin
				if (adv) begin
					// move the last entry into the hole
					we        = 1'b1;
					wr_addr   = hit_idx_q;
					wr_data   = rdata_s1;
					count_dec = 1'b1;
					emit_v    = 1'b1;
					emit_stat = ketq_pkg::STAT_REMOVED;
					emit_ent  = '{x: px_q, y: py_q, z: pz_q, v: '0};
					emit_cnt  = last_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ketq_pkg::ST_IDLE;
			enable_q   <= 1'b0;
			count_q    <= '0;
			rd_idx_q   <= '0;
			dv_s1_q    <= 1'b0;
			held_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) enable_q <= cfg_data;
			if (count_inc) count_q <= count_q + 1'b1;
			else if (count_dec) count_q <= last_idx;
			if (s_acc) begin
				rd_idx_q <= '0;
				dv_s1_q  <= 1'b0;
				held_v_q <= 1'b0;
			end else if (adv && (state_q == ketq_pkg::ST_SCAN)) begin
				dv_s1_q <= rd_en;
				if (rd_en) rd_idx_q <= rd_idx_q + 1'b1;
				if (hold_load) held_v_q <= 1'b1;
			end
			if (emit_v) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_acc) begin
			act_q  <= s_tuser;
			px_q   <= s_tdata[31:0];
			py_q   <= s_tdata[63:32];
			pz_q   <= s_tdata[95:64];
			nv_q   <= s_tdata[111:96];
			lo_x_q <= rp_ext * rsize;
			lo_z_q <= rq_ext * rsize;
		end
		if (hold_load) held_q <= rdata_s1;
		if (stop) hit_idx_q <= idx_s1;
		if (emit_v) begin
			out_stat_q <= emit_stat;
			out_ent_q  <= emit_ent;
			out_fill_q <= ketq_pkg::FILL_W'(emit_cnt);
			out_last_q <= emit_last;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) table_q[wr_addr] <= wr_data;
		if (rd_en) begin
			rdata_s1 <= table_q[rd_addr];
			idx_s1   <= rd_addr;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'b0, out_fill_q, out_ent_q.v, out_ent_q.z, out_ent_q.y,
		out_ent_q.x, out_stat_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + 1'b1) ||
			(count_q == $past(count_q) - 1'b1))
		else $error("fill count moved by more than one");

	a_dv_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s1_q |-> (state_q == ketq_pkg::ST_SCAN))
		else $error("read stage valid outside the scan");

	a_held_query: assert property (@(posedge clk) disable iff (!arst_n)
		held_v_q && (state_q != ketq_pkg::ST_IDLE) |-> (act_q == ketq_pkg::ACT_QUERY))
		else $error("match held during a write");

endmodule
